// ----- design/mfds_pkg.sv -----
// Shared types and constants for the melt fraction / Darcy source pipeline.
// No dependencies; used by the pipeline modules, the top level and the testbench.
`default_nettype none

package mfds_pkg;

   localparam int IDX_W  = 24;
   localparam int TEMP_W = 32;
   localparam int CP_W   = 31;
   localparam int FRAC_W = 17;
   localparam int VOL_W  = 31;
   localparam int SRC_W  = 48;
   localparam int CU_W   = 40;

   localparam int ADDR_W = 6;
   localparam int DATA_W = 64;

   // Darcy quotient: (Cu * sq) / (a3 + q)
   localparam int NUM_W       = 56;
   localparam int DEN_W       = 18;
   localparam int DIV_BITS    = 4;
   localparam int DIV_STAGES  = NUM_W / DIV_BITS;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

   typedef enum logic [2:0] {
      REG_MELT_TEMPERATURE    = 3'd0,
      REG_RELAXATION          = 3'd1,
      REG_INVERSE_LATENT_HEAT = 3'd2,
      REG_MUSHY_CONSTANT      = 3'd3,
      REG_SMALL_OFFSET        = 3'd4,
      REG_BUOYANCY_X          = 3'd5,
      REG_BUOYANCY_Y          = 3'd6,
      REG_BUOYANCY_Z          = 3'd7
   } reg_index_type;

   localparam logic [31:0]       RST_MELT_TEMPERATURE    = 32'd0;
   localparam logic [16:0]       RST_RELAXATION          = 17'd58982;
   localparam logic [31:0]       RST_INVERSE_LATENT_HEAT = 32'd0;
   localparam logic [CU_W-1:0]   RST_MUSHY_CONSTANT      = 40'd6553600000;
   localparam logic [16:0]       RST_SMALL_OFFSET        = 17'd66;
   localparam logic [SRC_W-1:0]  RST_BUOYANCY            = 48'd0;

   typedef struct packed {
      logic [31:0]      melt_temperature;
      logic [16:0]      relaxation;
      logic [31:0]      inverse_latent_heat;
      logic [CU_W-1:0]  mushy_constant;
      logic [16:0]      small_offset;
      logic [SRC_W-1:0] buoyancy_x;
      logic [SRC_W-1:0] buoyancy_y;
      logic [SRC_W-1:0] buoyancy_z;
   } cfg_type;

   // Per-cell results that ride along with the Darcy quotient
   typedef struct packed {
      logic [IDX_W-1:0]  cell_index;
      logic [FRAC_W-1:0] fraction;
      logic [TEMP_W-1:0] excess;
      logic [SRC_W-1:0]  source_x;
      logic [SRC_W-1:0]  source_y;
      logic [SRC_W-1:0]  source_z;
      logic [VOL_W-1:0]  volume;
   } carry_type;

endpackage

`default_nettype wire

// ----- design/mfds_front.sv -----
// Front pipeline: temperature excess, fraction update and buoyancy sources.
// Six register stages; depends on mfds_pkg.
`default_nettype none

module mfds_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire mfds_pkg::cfg_type                cfg,
   input  wire logic                             in_valid,
   input  wire logic [mfds_pkg::IDX_W-1:0]       in_index,
   input  wire logic [mfds_pkg::TEMP_W-1:0]      in_temp,
   input  wire logic [mfds_pkg::CP_W-1:0]        in_cp,
   input  wire logic [mfds_pkg::FRAC_W-1:0]      in_old,
   input  wire logic [mfds_pkg::VOL_W-1:0]       in_vol,
   output logic                                  out_valid,
   output mfds_pkg::carry_type                   out_carry
);

   logic [5:0] v_ff;

   // stage 1
   logic [32:0] dt_in, dtmag_in;
   logic [31:0] xs_in;
   logic [23:0] s1_idx_ff;
   logic        s1_neg_ff;
   logic [32:0] s1_dtmag_ff;
   logic [31:0] s1_xs_ff;
   logic [30:0] s1_cp_ff;
   logic [16:0] s1_old_ff;
   logic [30:0] s1_vol_ff;

   // stage 2
   logic [63:0] pprod_in, mprod_in;
   logic [31:0] xsmag_in;
   logic [23:0] s2_idx_ff;
   logic        s2_neg_ff;
   logic [31:0] s2_xs_ff;
   logic [16:0] s2_old_ff;
   logic [30:0] s2_vol_ff;
   logic [46:0] s2_p_ff;
   logic [46:0] s2_m_ff;

   // stage 3
   logic [47:0] bvec [3];
   logic [47:0] bmag_in [3];
   logic [23:0] s3_idx_ff;
   logic        s3_neg_ff;
   logic [31:0] s3_xs_ff;
   logic [16:0] s3_old_ff;
   logic [30:0] s3_vol_ff;
   logic [63:0] s3_pfh_ff;
   logic [47:0] s3_pfl_ff;
   logic [47:0] s3_hh_ff [3];
   logic [47:0] s3_hl_ff [3];
   logic [47:0] s3_lh_ff [3];
   logic [47:0] s3_ll_ff [3];
   logic [2:0]  s3_bneg_ff;

   // stage 4
   logic [79:0] pfull_in;
   logic [95:0] bfull_in [3];
   logic [23:0] s4_idx_ff;
   logic        s4_neg_ff;
   logic [31:0] s4_xs_ff;
   logic [16:0] s4_old_ff;
   logic [30:0] s4_vol_ff;
   logic [46:0] s4_p2_ff;
   logic [78:0] s4_bsum_ff [3];
   logic [2:0]  s4_bneg_ff;

   // stage 5
   logic [63:0] iprod_in;
   logic [47:0] src_in [3];
   logic [47:0] cap_in [3];
   logic [47:0] r_in [3];
   logic [23:0] s5_idx_ff;
   logic        s5_neg_ff;
   logic [31:0] s5_xs_ff;
   logic [16:0] s5_old_ff;
   logic [30:0] s5_vol_ff;
   logic [20:0] s5_inc_ff;
   logic [47:0] s5_src_ff [3];

   // stage 6
   logic [22:0] nf_in;
   logic [16:0] frac_in;
   mfds_pkg::carry_type s6_carry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   assign out_valid = v_ff[5];
   assign out_carry = s6_carry_ff;

   // stage 1: excess over melting point
   always_comb begin
      dt_in    = {in_temp[31], in_temp} - {cfg.melt_temperature[31], cfg.melt_temperature};
      dtmag_in = dt_in[32] ? (33'd0 - dt_in) : dt_in;
      if (dt_in[32] != dt_in[31]) begin
         xs_in = dt_in[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         xs_in = dt_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_idx_ff   <= in_index;
         s1_neg_ff   <= dt_in[32];
         s1_dtmag_ff <= dtmag_in;
         s1_xs_ff    <= xs_in;
         s1_cp_ff    <= in_cp;
         s1_old_ff   <= in_old;
         s1_vol_ff   <= in_vol;
      end
   end

   // stage 2: Cp*|dT| and V*|Xs|
   always_comb begin
      xsmag_in = s1_xs_ff[31] ? (32'd0 - s1_xs_ff) : s1_xs_ff;
      pprod_in = 64'(s1_cp_ff) * 64'(s1_dtmag_ff);
      mprod_in = 64'(s1_vol_ff) * 64'(xsmag_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_idx_ff <= s1_idx_ff;
         s2_neg_ff <= s1_neg_ff;
         s2_xs_ff  <= s1_xs_ff;
         s2_old_ff <= s1_old_ff;
         s2_vol_ff <= s1_vol_ff;
         s2_p_ff   <= pprod_in[62:16];
         s2_m_ff   <= mprod_in[62:16];
      end
   end

   // stage 3: partial products
   always_comb begin
      bvec[0] = cfg.buoyancy_x;
      bvec[1] = cfg.buoyancy_y;
      bvec[2] = cfg.buoyancy_z;
      for (int k = 0; k < 3; k++) begin
         bmag_in[k] = bvec[k][47] ? (48'd0 - bvec[k]) : bvec[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_idx_ff <= s2_idx_ff;
         s3_neg_ff <= s2_neg_ff;
         s3_xs_ff  <= s2_xs_ff;
         s3_old_ff <= s2_old_ff;
         s3_vol_ff <= s2_vol_ff;
         s3_pfh_ff <= 64'(s2_p_ff[46:16]) * 64'(cfg.inverse_latent_heat);
         s3_pfl_ff <= 48'(s2_p_ff[15:0]) * 48'(cfg.inverse_latent_heat);
         for (int k = 0; k < 3; k++) begin
            s3_hh_ff[k]   <= 48'(s2_m_ff[46:24]) * 48'(bmag_in[k][47:24]);
            s3_hl_ff[k]   <= 48'(s2_m_ff[46:24]) * 48'(bmag_in[k][23:0]);
            s3_lh_ff[k]   <= 48'(s2_m_ff[23:0])  * 48'(bmag_in[k][47:24]);
            s3_ll_ff[k]   <= 48'(s2_m_ff[23:0])  * 48'(bmag_in[k][23:0]);
            s3_bneg_ff[k] <= bvec[k][47] != s2_xs_ff[31];
         end
      end
   end

   // stage 4: assemble the wide products
   always_comb begin
      pfull_in = (80'(s3_pfh_ff) << 16) + 80'(s3_pfl_ff);
      for (int k = 0; k < 3; k++) begin
         bfull_in[k] = (96'(s3_hh_ff[k]) << 48)
                     + ((96'(s3_hl_ff[k]) + 96'(s3_lh_ff[k])) << 24)
                     + 96'(s3_ll_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_idx_ff  <= s3_idx_ff;
         s4_neg_ff  <= s3_neg_ff;
         s4_xs_ff   <= s3_xs_ff;
         s4_old_ff  <= s3_old_ff;
         s4_vol_ff  <= s3_vol_ff;
         s4_p2_ff   <= pfull_in[78:32];
         s4_bneg_ff <= s3_bneg_ff;
         for (int k = 0; k < 3; k++) begin
            s4_bsum_ff[k] <= bfull_in[k][94:16];
         end
      end
   end

   // stage 5: relaxed increment, saturate sources
   always_comb begin
      iprod_in = 64'(s4_p2_ff) * 64'(cfg.relaxation);
      for (int k = 0; k < 3; k++) begin
         cap_in[k] = s4_bneg_ff[k] ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
         r_in[k]   = (s4_bsum_ff[k] > 79'(cap_in[k])) ? cap_in[k] : s4_bsum_ff[k][47:0];
         src_in[k] = s4_bneg_ff[k] ? (48'd0 - r_in[k]) : r_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_idx_ff <= s4_idx_ff;
         s5_neg_ff <= s4_neg_ff;
         s5_xs_ff  <= s4_xs_ff;
         s5_old_ff <= s4_old_ff;
         s5_vol_ff <= s4_vol_ff;
         s5_inc_ff <= (iprod_in[63:16] > 48'd1048576) ? 21'd1048576 : iprod_in[36:16];
         for (int k = 0; k < 3; k++) begin
            s5_src_ff[k] <= src_in[k];
         end
      end
   end

   // stage 6: clamp fraction to [0,1]
   always_comb begin
      nf_in = s5_neg_ff ? (23'(s5_old_ff) - 23'(s5_inc_ff))
                        : (23'(s5_old_ff) + 23'(s5_inc_ff));
      if (nf_in[22]) begin
         frac_in = '0;
      end else if (nf_in > 23'(mfds_pkg::FRAC_ONE)) begin
         frac_in = mfds_pkg::FRAC_ONE;
      end else begin
         frac_in = nf_in[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_carry_ff.cell_index <= s5_idx_ff;
         s6_carry_ff.fraction   <= frac_in;
         s6_carry_ff.excess     <= s5_xs_ff;
         s6_carry_ff.source_x   <= s5_src_ff[0];
         s6_carry_ff.source_y   <= s5_src_ff[1];
         s6_carry_ff.source_z   <= s5_src_ff[2];
         s6_carry_ff.volume     <= s5_vol_ff;
      end
   end

endmodule

`default_nettype wire

// ----- design/mfds_darcy.sv -----
// Carman-Kozeny numerator and denominator from the new liquid fraction.
// Three register stages; depends on mfds_pkg.
`default_nettype none

module mfds_darcy (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire mfds_pkg::cfg_type                cfg,
   input  wire logic                             in_valid,
   input  wire mfds_pkg::carry_type              in_carry,
   output logic                                  out_valid,
   output mfds_pkg::carry_type                   out_carry,
   output logic [mfds_pkg::NUM_W-1:0]            out_num,
   output logic [mfds_pkg::DEN_W-1:0]            out_den
);

   logic [2:0]  v_ff;
   logic [16:0] om_in;
   logic [33:0] a2p_in, sqp_in, a3p_in;
   logic [56:0] nump_in;
   logic [17:0] den_in;

   mfds_pkg::carry_type d1_carry_ff, d2_carry_ff, d3_carry_ff;
   logic [16:0] d1_a2_ff, d1_sq_ff;
   logic [16:0] d2_a3_ff;
   logic [mfds_pkg::NUM_W-1:0] d2_num_ff, d3_num_ff;
   logic [mfds_pkg::DEN_W-1:0] d3_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_comb begin
      om_in   = mfds_pkg::FRAC_ONE - in_carry.fraction;
      a2p_in  = 34'(in_carry.fraction) * 34'(in_carry.fraction);
      sqp_in  = 34'(om_in) * 34'(om_in);
      a3p_in  = 34'(d1_a2_ff) * 34'(d1_carry_ff.fraction);
      nump_in = 57'(cfg.mushy_constant) * 57'(d1_sq_ff);
      den_in  = 18'(d2_a3_ff) + 18'(cfg.small_offset);
      // guard the zero divisor
      if (den_in == '0) begin
         den_in = 18'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_carry_ff <= in_carry;
         d1_a2_ff    <= a2p_in[32:16];
         d1_sq_ff    <= sqp_in[32:16];
         d2_carry_ff <= d1_carry_ff;
         d2_a3_ff    <= a3p_in[32:16];
         d2_num_ff   <= nump_in[mfds_pkg::NUM_W-1:0];
         d3_carry_ff <= d2_carry_ff;
         d3_num_ff   <= d2_num_ff;
         d3_den_ff   <= den_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_carry = d3_carry_ff;
   assign out_num   = d3_num_ff;
   assign out_den   = d3_den_ff;

endmodule

`default_nettype wire

// ----- design/mfds_div.sv -----
// Pipelined restoring divider, DIV_BITS quotient bits per stage.
// Carries the per-cell results alongside; depends on mfds_pkg.
`default_nettype none

module mfds_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire logic                             in_valid,
   input  wire mfds_pkg::carry_type              in_carry,
   input  wire logic [mfds_pkg::NUM_W-1:0]       in_num,
   input  wire logic [mfds_pkg::DEN_W-1:0]       in_den,
   output logic                                  out_valid,
   output mfds_pkg::carry_type                   out_carry,
   output logic [mfds_pkg::NUM_W-1:0]            out_quot
);

   localparam int NS = mfds_pkg::DIV_STAGES;
   localparam int NW = mfds_pkg::NUM_W;
   localparam int DW = mfds_pkg::DEN_W;

   logic [NS-1:0]       v_ff;
   logic [DW-1:0]       rem_ff   [NS];
   logic [NW-1:0]       qn_ff    [NS];
   logic [DW-1:0]       den_ff   [NS];
   mfds_pkg::carry_type carry_ff [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic [DW-1:0]       rem_src;
      logic [NW-1:0]       qn_src;
      logic [DW-1:0]       den_src;
      mfds_pkg::carry_type carry_src;
      logic [DW-1:0]       rem_in;
      logic [NW-1:0]       qn_in;
      logic [DW:0]         trial;

      if (g == 0) begin : g_first
         assign rem_src   = '0;
         assign qn_src    = in_num;
         assign den_src   = in_den;
         assign carry_src = in_carry;
      end else begin : g_next
         assign rem_src   = rem_ff[g-1];
         assign qn_src    = qn_ff[g-1];
         assign den_src   = den_ff[g-1];
         assign carry_src = carry_ff[g-1];
      end

      // shift in DIV_BITS numerator bits one at a time, subtract when it fits
      always_comb begin
         rem_in = rem_src;
         qn_in  = qn_src;
         trial  = '0;
         for (int b = 0; b < mfds_pkg::DIV_BITS; b++) begin
            trial = {rem_in, qn_in[NW-1]};
            qn_in = {qn_in[NW-2:0], 1'b0};
            if (trial >= {1'b0, den_src}) begin
               trial    = trial - {1'b0, den_src};
               qn_in[0] = 1'b1;
            end
            rem_in = trial[DW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]   <= rem_in;
            qn_ff[g]    <= qn_in;
            den_ff[g]   <= den_src;
            carry_ff[g] <= carry_src;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_carry = carry_ff[NS-1];
   assign out_quot  = qn_ff[NS-1];

endmodule

`default_nettype wire

// ----- design/mfds_back.sv -----
// Volume scaling of the Darcy coefficient and the output register.
// Two register stages; depends on mfds_pkg.
`default_nettype none

module mfds_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire logic                             in_valid,
   input  wire mfds_pkg::carry_type              in_carry,
   input  wire logic [mfds_pkg::NUM_W-1:0]       in_quot,
   output logic                                  out_valid,
   output mfds_pkg::carry_type                   out_carry,
   output logic [mfds_pkg::SRC_W-1:0]            out_diag
);

   logic [1:0]  v_ff;
   mfds_pkg::carry_type b1_carry_ff, b2_carry_ff;
   logic [58:0] b1_ph_ff, b1_pl_ff;
   logic [86:0] sum_in;
   logic [47:0] d_in;
   logic [47:0] b2_diag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[0], in_valid};
      end
   end

   always_comb begin
      sum_in = (87'(b1_ph_ff) << 28) + 87'(b1_pl_ff);
      // cap the magnitude at 2^47
      if (sum_in[86:16] > 71'h8000_0000_0000) begin
         d_in = 48'h8000_0000_0000;
      end else begin
         d_in = sum_in[63:16];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_carry_ff <= in_carry;
         b1_ph_ff    <= 59'(in_carry.volume) * 59'(in_quot[55:28]);
         b1_pl_ff    <= 59'(in_carry.volume) * 59'(in_quot[27:0]);
         b2_carry_ff <= b1_carry_ff;
         b2_diag_ff  <= 48'd0 - d_in;
      end
   end

   assign out_valid = v_ff[1];
   assign out_carry = b2_carry_ff;
   assign out_diag  = b2_diag_ff;

endmodule

`default_nettype wire

// ----- design/melt_fraction_darcy_source.sv -----
// Top level of the enthalpy-porosity melting source: register file and pipeline.
// Instantiates mfds_front, mfds_darcy, mfds_div, mfds_back; depends on mfds_pkg.
//
//   port group   direction  flow control      contents
//   req_*        in         valid / stall     one mesh cell per transaction
//   rsp_*        out        valid / stall     one result per cell
//   APB          in / out   psel / penable    eight setting registers, 8-byte spaced
//
// The pipeline has 6 front stages, 3 Darcy stages, 14 divider stages (4 quotient bits
// each) and 2 output stages. One transaction enters per cycle unless the pipeline holds.
// The whole pipeline advances together; it holds while the result is stalled.
// Reset clears the valid bits and loads the register defaults.
`default_nettype none

module melt_fraction_darcy_source (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [mfds_pkg::IDX_W-1:0]       req_cell_index,
   input  wire logic [mfds_pkg::TEMP_W-1:0]      req_temperature,
   input  wire logic [mfds_pkg::CP_W-1:0]        req_heat_capacity,
   input  wire logic [mfds_pkg::FRAC_W-1:0]      req_fraction_old,
   input  wire logic [mfds_pkg::VOL_W-1:0]       req_cell_volume,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [mfds_pkg::IDX_W-1:0]            rsp_cell_index_out,
   output logic [mfds_pkg::FRAC_W-1:0]           rsp_fraction_new,
   output logic [mfds_pkg::TEMP_W-1:0]           rsp_temperature_excess,
   output logic [mfds_pkg::SRC_W-1:0]            rsp_diagonal_increment,
   output logic [mfds_pkg::SRC_W-1:0]            rsp_source_x,
   output logic [mfds_pkg::SRC_W-1:0]            rsp_source_y,
   output logic [mfds_pkg::SRC_W-1:0]            rsp_source_z,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [mfds_pkg::ADDR_W-1:0]      paddr,
   input  wire logic [mfds_pkg::DATA_W-1:0]      pwdata,
   output logic [mfds_pkg::DATA_W-1:0]           prdata,
   output logic                                  pready
);

   mfds_pkg::cfg_type cfg_ff;
   mfds_pkg::reg_index_type reg_sel;
   logic en;

   logic                         f_valid, dz_valid, dv_valid, bk_valid;
   mfds_pkg::carry_type          f_carry, dz_carry, dv_carry, bk_carry;
   logic [mfds_pkg::NUM_W-1:0]   dz_num, dv_quot;
   logic [mfds_pkg::DEN_W-1:0]   dz_den;
   logic [mfds_pkg::SRC_W-1:0]   bk_diag;

   assign reg_sel = mfds_pkg::reg_index_type'(paddr[5:3]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.melt_temperature    <= mfds_pkg::RST_MELT_TEMPERATURE;
         cfg_ff.relaxation          <= mfds_pkg::RST_RELAXATION;
         cfg_ff.inverse_latent_heat <= mfds_pkg::RST_INVERSE_LATENT_HEAT;
         cfg_ff.mushy_constant      <= mfds_pkg::RST_MUSHY_CONSTANT;
         cfg_ff.small_offset        <= mfds_pkg::RST_SMALL_OFFSET;
         cfg_ff.buoyancy_x          <= mfds_pkg::RST_BUOYANCY;
         cfg_ff.buoyancy_y          <= mfds_pkg::RST_BUOYANCY;
         cfg_ff.buoyancy_z          <= mfds_pkg::RST_BUOYANCY;
      end else if (psel && penable && pwrite) begin
         case (reg_sel)
            mfds_pkg::REG_MELT_TEMPERATURE:    cfg_ff.melt_temperature    <= pwdata[31:0];
            mfds_pkg::REG_RELAXATION:          cfg_ff.relaxation          <= pwdata[16:0];
            mfds_pkg::REG_INVERSE_LATENT_HEAT: cfg_ff.inverse_latent_heat <= pwdata[31:0];
            mfds_pkg::REG_MUSHY_CONSTANT:      cfg_ff.mushy_constant      <= pwdata[39:0];
            mfds_pkg::REG_SMALL_OFFSET:        cfg_ff.small_offset        <= pwdata[16:0];
            mfds_pkg::REG_BUOYANCY_X:          cfg_ff.buoyancy_x          <= pwdata[47:0];
            mfds_pkg::REG_BUOYANCY_Y:          cfg_ff.buoyancy_y          <= pwdata[47:0];
            mfds_pkg::REG_BUOYANCY_Z:          cfg_ff.buoyancy_z          <= pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         mfds_pkg::REG_MELT_TEMPERATURE:    prdata = 64'(cfg_ff.melt_temperature);
         mfds_pkg::REG_RELAXATION:          prdata = 64'(cfg_ff.relaxation);
         mfds_pkg::REG_INVERSE_LATENT_HEAT: prdata = 64'(cfg_ff.inverse_latent_heat);
         mfds_pkg::REG_MUSHY_CONSTANT:      prdata = 64'(cfg_ff.mushy_constant);
         mfds_pkg::REG_SMALL_OFFSET:        prdata = 64'(cfg_ff.small_offset);
         mfds_pkg::REG_BUOYANCY_X:          prdata = 64'(cfg_ff.buoyancy_x);
         mfds_pkg::REG_BUOYANCY_Y:          prdata = 64'(cfg_ff.buoyancy_y);
         mfds_pkg::REG_BUOYANCY_Z:          prdata = 64'(cfg_ff.buoyancy_z);
         default:                           prdata = '0;
      endcase
   end

   // advance unless a finished result is held
   assign en        = !bk_valid || !rsp_stall;
   assign req_stall = !en;

   mfds_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_index  (req_cell_index),
      .in_temp   (req_temperature),
      .in_cp     (req_heat_capacity),
      .in_old    (req_fraction_old),
      .in_vol    (req_cell_volume),
      .out_valid (f_valid),
      .out_carry (f_carry)
   );

   mfds_darcy u_darcy (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (f_valid),
      .in_carry  (f_carry),
      .out_valid (dz_valid),
      .out_carry (dz_carry),
      .out_num   (dz_num),
      .out_den   (dz_den)
   );

   mfds_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dz_valid),
      .in_carry  (dz_carry),
      .in_num    (dz_num),
      .in_den    (dz_den),
      .out_valid (dv_valid),
      .out_carry (dv_carry),
      .out_quot  (dv_quot)
   );

   mfds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid),
      .in_carry  (dv_carry),
      .in_quot   (dv_quot),
      .out_valid (bk_valid),
      .out_carry (bk_carry),
      .out_diag  (bk_diag)
   );

   assign rsp_valid              = bk_valid;
   assign rsp_cell_index_out     = bk_carry.cell_index;
   assign rsp_fraction_new       = bk_carry.fraction;
   assign rsp_temperature_excess = bk_carry.excess;
   assign rsp_diagonal_increment = bk_diag;
   assign rsp_source_x           = bk_carry.source_x;
   assign rsp_source_y           = bk_carry.source_y;
   assign rsp_source_z           = bk_carry.source_z;

endmodule

`default_nettype wire

// ----- design/mfds_checker.sv -----
// Port-level checks for melt_fraction_darcy_source, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module mfds_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_stall,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [23:0] rsp_cell_index_out,
   input  wire logic [16:0] rsp_fraction_new,
   input  wire logic [47:0] rsp_diagonal_increment
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_index_out)
                                 && $stable(rsp_fraction_new))
      else $error("stalled transaction changed");

   a_frac: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fraction_new <= 17'd65536)
      else $error("fraction above one");

   a_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_diagonal_increment[47] || rsp_diagonal_increment == 48'd0)
      else $error("diagonal increment positive");

   a_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with no held result");

   a_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind melt_fraction_darcy_source mfds_checker u_mfds_checker (.*);

`default_nettype wire

// ----- tb/mfds_checker.sv -----
// Checker for melt_fraction_darcy_source: snoops APB writes, predicts each cell's
// result and compares it with the response channel. Depends on mfds_pkg.
`default_nettype none

module mfds_scoreboard (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic [mfds_pkg::IDX_W-1:0]   req_cell_index,
   input  wire logic [mfds_pkg::TEMP_W-1:0]  req_temperature,
   input  wire logic [mfds_pkg::CP_W-1:0]    req_heat_capacity,
   input  wire logic [mfds_pkg::FRAC_W-1:0]  req_fraction_old,
   input  wire logic [mfds_pkg::VOL_W-1:0]   req_cell_volume,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic [mfds_pkg::IDX_W-1:0]   rsp_cell_index_out,
   input  wire logic [mfds_pkg::FRAC_W-1:0]  rsp_fraction_new,
   input  wire logic [mfds_pkg::TEMP_W-1:0]  rsp_temperature_excess,
   input  wire logic [mfds_pkg::SRC_W-1:0]   rsp_diagonal_increment,
   input  wire logic [mfds_pkg::SRC_W-1:0]   rsp_source_x,
   input  wire logic [mfds_pkg::SRC_W-1:0]   rsp_source_y,
   input  wire logic [mfds_pkg::SRC_W-1:0]   rsp_source_z,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [mfds_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [mfds_pkg::DATA_W-1:0]  pwdata,
   input  wire logic                         pready,
   output int                                fail_count,
   output int                                cells_pending,
   output int                                cells_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import mfds_pkg::*;

   typedef struct {
      logic [IDX_W-1:0]  cell_index;
      logic [FRAC_W-1:0] fraction;
      logic [TEMP_W-1:0] excess;
      logic [SRC_W-1:0]  diagonal;
      logic [SRC_W-1:0]  source_x;
      logic [SRC_W-1:0]  source_y;
      logic [SRC_W-1:0]  source_z;
   } cell_result_type;

   localparam logic [63:0] CAP47 = 64'h7FFF_FFFF_FFFF;
   localparam logic [63:0] NEG47 = 64'h8000_0000_0000;

   cfg_type         settings;
   cell_result_type expected_cells[$];

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want, input logic [IDX_W-1:0] idx);
      $display("mismatch cell %0d %s: got %h expected %h", idx, field, got, want);
      fail_count++;
   endtask

   // volume * saturated excess * buoyancy coefficient, sign from both
   function automatic logic [SRC_W-1:0] buoyancy_term(input logic [VOL_W-1:0] vol,
                                                      input longint xs,
                                                      input logic [SRC_W-1:0] coef);
      longint       b;
      logic [63:0]  xmag, bmag, m, r;
      logic [127:0] w;
      logic         neg;
      b    = longint'($signed(coef));
      xmag = xs < 0 ? 64'(-xs) : 64'(xs);
      bmag = b < 0 ? 64'(-b) : 64'(b);
      m    = 64'((128'(vol) * 128'(xmag)) >> 16);
      neg  = (b < 0) != (xs < 0);
      w    = (128'(m) * 128'(bmag)) >> 16;
      r    = w > 128'(neg ? NEG47 : CAP47) ? (neg ? NEG47 : CAP47) : w[63:0];
      return neg ? SRC_W'(64'd0 - r) : r[SRC_W-1:0];
   endfunction

   function automatic cell_result_type melt_cell_result(input logic [IDX_W-1:0] idx,
                                                        input logic [TEMP_W-1:0] temp,
                                                        input logic [CP_W-1:0] cp,
                                                        input logic [FRAC_W-1:0] old,
                                                        input logic [VOL_W-1:0] vol);
      longint          dt, xs, nf;
      logic [63:0]     dmag, p, inc, a, a2, a3, om, sq, den, s, d;
      logic [127:0]    w;
      cell_result_type r;
      dt   = longint'($signed(temp)) - longint'($signed(settings.melt_temperature));
      xs   = dt > 64'sd2147483647 ? 64'sd2147483647 :
             (dt < -64'sd2147483648 ? -64'sd2147483648 : dt);
      dmag = dt < 0 ? 64'(-dt) : 64'(dt);
      p    = 64'((128'(cp) * 128'(dmag)) >> 16);
      p    = 64'((128'(p) * 128'(settings.inverse_latent_heat)) >> 32);
      w    = (128'(p) * 128'(settings.relaxation)) >> 16;
      inc  = w > 128'(1 << 20) ? 64'(1 << 20) : w[63:0];
      nf   = dt < 0 ? longint'(old) - longint'(inc) : longint'(old) + longint'(inc);
      if (nf < 0) nf = 0;
      if (nf > 65536) nf = 65536;
      a    = 64'(nf);
      a2   = (a * a) >> 16;
      a3   = (a2 * a) >> 16;
      om   = 64'd65536 - a;
      sq   = (om * om) >> 16;
      den  = a3 + 64'(settings.small_offset);
      if (den == 0) den = 1;
      s    = (64'(settings.mushy_constant) * sq) / den;
      w    = (128'(vol) * 128'(s)) >> 16;
      d    = w > 128'(NEG47) ? NEG47 : w[63:0];
      r.cell_index = idx;
      r.fraction   = a[FRAC_W-1:0];
      r.excess     = xs[31:0];
      r.diagonal   = SRC_W'(64'd0 - d);
      r.source_x   = buoyancy_term(vol, xs, settings.buoyancy_x);
      r.source_y   = buoyancy_term(vol, xs, settings.buoyancy_y);
      r.source_z   = buoyancy_term(vol, xs, settings.buoyancy_z);
      return r;
   endfunction

   always @(posedge clock) begin
      cell_result_type exp_cell;
      if (reset) begin
         settings.melt_temperature    = RST_MELT_TEMPERATURE;
         settings.relaxation          = RST_RELAXATION;
         settings.inverse_latent_heat = RST_INVERSE_LATENT_HEAT;
         settings.mushy_constant      = RST_MUSHY_CONSTANT;
         settings.small_offset        = RST_SMALL_OFFSET;
         settings.buoyancy_x          = RST_BUOYANCY;
         settings.buoyancy_y          = RST_BUOYANCY;
         settings.buoyancy_z          = RST_BUOYANCY;
         expected_cells.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[5:3]))
               REG_MELT_TEMPERATURE:    settings.melt_temperature    = pwdata[31:0];
               REG_RELAXATION:          settings.relaxation          = pwdata[16:0];
               REG_INVERSE_LATENT_HEAT: settings.inverse_latent_heat = pwdata[31:0];
               REG_MUSHY_CONSTANT:      settings.mushy_constant      = pwdata[CU_W-1:0];
               REG_SMALL_OFFSET:        settings.small_offset        = pwdata[16:0];
               REG_BUOYANCY_X:          settings.buoyancy_x          = pwdata[SRC_W-1:0];
               REG_BUOYANCY_Y:          settings.buoyancy_y          = pwdata[SRC_W-1:0];
               REG_BUOYANCY_Z:          settings.buoyancy_z          = pwdata[SRC_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_cells.push_back(melt_cell_result(req_cell_index, req_temperature,
               req_heat_capacity, req_fraction_old, req_cell_volume));
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               $display("unexpected transaction for cell %0d", rsp_cell_index_out);
               fail_count++;
            end else begin
               exp_cell = expected_cells.pop_front();
               cells_checked++;
               if (rsp_cell_index_out !== exp_cell.cell_index)
                  report_mismatch("cell_index_out", 64'(rsp_cell_index_out),
                                  64'(exp_cell.cell_index), exp_cell.cell_index);
               if (rsp_fraction_new !== exp_cell.fraction)
                  report_mismatch("fraction_new", 64'(rsp_fraction_new),
                                  64'(exp_cell.fraction), exp_cell.cell_index);
               if (rsp_temperature_excess !== exp_cell.excess)
                  report_mismatch("temperature_excess", 64'(rsp_temperature_excess),
                                  64'(exp_cell.excess), exp_cell.cell_index);
               if (rsp_diagonal_increment !== exp_cell.diagonal)
                  report_mismatch("diagonal_increment", 64'(rsp_diagonal_increment),
                                  64'(exp_cell.diagonal), exp_cell.cell_index);
               if (rsp_source_x !== exp_cell.source_x)
                  report_mismatch("source_x", 64'(rsp_source_x),
                                  64'(exp_cell.source_x), exp_cell.cell_index);
               if (rsp_source_y !== exp_cell.source_y)
                  report_mismatch("source_y", 64'(rsp_source_y),
                                  64'(exp_cell.source_y), exp_cell.cell_index);
               if (rsp_source_z !== exp_cell.source_z)
                  report_mismatch("source_z", 64'(rsp_source_z),
                                  64'(exp_cell.source_z), exp_cell.cell_index);
            end
         end
      end
      cells_pending = expected_cells.size();
   end

   initial begin
      fail_count    = 0;
      cells_pending = 0;
      cells_checked = 0;
   end

endmodule

`default_nettype wire

// ----- tb/tb_melt_fraction_darcy_source.sv -----
// Testbench top for melt_fraction_darcy_source: clock, reset, APB setup, cell stimulus
// and verdict. Depends on mfds_pkg, the block and mfds_scoreboard.
`default_nettype none

module tb_melt_fraction_darcy_source;
   timeunit 1ns;
   timeprecision 1ps;
   import mfds_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [IDX_W-1:0]    req_cell_index;
   logic [TEMP_W-1:0]   req_temperature;
   logic [CP_W-1:0]     req_heat_capacity;
   logic [FRAC_W-1:0]   req_fraction_old;
   logic [VOL_W-1:0]    req_cell_volume;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [IDX_W-1:0]    rsp_cell_index_out;
   logic [FRAC_W-1:0]   rsp_fraction_new;
   logic [TEMP_W-1:0]   rsp_temperature_excess;
   logic [SRC_W-1:0]    rsp_diagonal_increment;
   logic [SRC_W-1:0]    rsp_source_x;
   logic [SRC_W-1:0]    rsp_source_y;
   logic [SRC_W-1:0]    rsp_source_z;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   int                  fail_count;
   int                  cells_pending;
   int                  cells_checked;
   int                  cycle_count;
   int                  settings_used;
   int                  burst_left;
   logic                req_fire;
   logic [31:0]         melt_setting;

   melt_fraction_darcy_source u_top (.*);
   mfds_scoreboard u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver stall pattern: free, light and heavy stretches
   always @(negedge clock) begin
      int mode;
      if (cycle_count % 97 == 0) mode = $urandom_range(0, 2);
      case (mode)
         0: rsp_stall = 1'b0;
         1: rsp_stall = ($urandom_range(0, 3) == 0);
         default: rsp_stall = ($urandom_range(0, 9) < 7);
      endcase
   end

   task automatic write_reg(input reg_index_type r, input logic [63:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = ADDR_W'({r, 3'b000});
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic load_settings(input logic [31:0] mt, input logic [16:0] relax,
                                input logic [31:0] inv_l, input logic [39:0] cu,
                                input logic [16:0] q, input logic [47:0] bx,
                                input logic [47:0] by, input logic [47:0] bz);
      write_reg(REG_MELT_TEMPERATURE, 64'(mt));
      write_reg(REG_RELAXATION, 64'(relax));
      write_reg(REG_INVERSE_LATENT_HEAT, 64'(inv_l));
      write_reg(REG_MUSHY_CONSTANT, 64'(cu));
      write_reg(REG_SMALL_OFFSET, 64'(q));
      write_reg(REG_BUOYANCY_X, 64'(bx));
      write_reg(REG_BUOYANCY_Y, 64'(by));
      write_reg(REG_BUOYANCY_Z, 64'(bz));
      melt_setting = mt;
      settings_used++;
   endtask

   // one transaction; valid stays high on return so a burst flows back to back
   task automatic send_cell(input logic [IDX_W-1:0] idx, input logic [TEMP_W-1:0] temp,
                            input logic [CP_W-1:0] cp, input logic [FRAC_W-1:0] old,
                            input logic [VOL_W-1:0] vol);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid         = 1'b1;
      req_cell_index    = idx;
      req_temperature   = temp;
      req_heat_capacity = cp;
      req_fraction_old  = old;
      req_cell_volume   = vol;
      do @(negedge clock); while (!req_fire);
      burst_left--;
   endtask

   task automatic drain;
      req_valid = 1'b0;
      while (cells_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] shrunk32;
      return $urandom >> $urandom_range(0, 31);
   endfunction

   task automatic send_random_cell;
      logic [TEMP_W-1:0] temp;
      logic [FRAC_W-1:0] old;
      // most cells sit near the melting point so the fraction moves inside (0,1)
      case ($urandom_range(0, 3))
         0: temp = $urandom;
         1: temp = melt_setting + 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
         default: temp = melt_setting + 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
      endcase
      old = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 131071))
                                        : 17'($urandom_range(0, 65536));
      send_cell(24'($urandom), temp, 31'(shrunk32()), old, 31'(shrunk32()));
   endtask

   task automatic run_random_setting(input int cells);
      load_settings($urandom, 17'($urandom_range(0, 70000)), shrunk32(),
                    {8'($urandom_range(0, 3) == 0 ? $urandom : 0), shrunk32()},
                    17'($urandom_range(0, 4000)),
                    {16'($urandom) >> $urandom_range(0, 16), shrunk32()},
                    {16'($urandom) >> $urandom_range(0, 16), shrunk32()},
                    {16'($urandom) >> $urandom_range(0, 16), shrunk32()});
      repeat (cells) send_random_cell();
      drain();
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_cell_index    = '0;
      req_temperature   = '0;
      req_heat_capacity = '0;
      req_fraction_old  = '0;
      req_cell_volume   = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      cycle_count  = 0;
      settings_used = 1;
      burst_left   = 0;
      melt_setting = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset defaults: field extremes, fraction above one, zero volume
      send_cell(24'h0, 32'h8000_0000, 31'h0, 17'd0, 31'h0);
      send_cell(24'hFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 17'd65536, 31'h7FFF_FFFF);
      send_cell(24'h123456, 32'h0, 31'h10000, 17'h1FFFF, 31'h10000);
      send_cell(24'h5, 32'hFFFF_0000, 31'h7FFF_FFFF, 17'd32768, 31'h7FFF_FFFF);
      drain();

      // extremes: saturating excess, full relaxation, largest Cu and buoyancy
      load_settings(32'h8000_0000, 17'd65536, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 17'd1,
                    48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0000_0001_0000);
      send_cell(24'd1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 17'd0, 31'h7FFF_FFFF);
      send_cell(24'd2, 32'h8000_0000, 31'h7FFF_FFFF, 17'd65536, 31'h7FFF_FFFF);
      send_cell(24'd3, 32'h8000_0001, 31'h1, 17'd1, 31'h1);
      send_cell(24'd4, 32'h0, 31'h7FFF_FFFF, 17'd0, 31'h7FFF_FFFF);
      drain();

      // zero offset gives a zero denominator once the fraction reaches zero
      load_settings(32'h0010_0000, 17'd0, 32'd0, 40'd6553600000, 17'd0,
                    48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h0);
      send_cell(24'd10, 32'h0, 31'h10000, 17'd0, 31'h7FFF_FFFF);
      send_cell(24'd11, 32'h0020_0000, 31'h10000, 17'd0, 31'h10000);
      send_cell(24'd12, 32'h7FFF_FFFF, 31'h0, 17'd65536, 31'h7FFF_FFFF);
      drain();

      // relaxation above one, melt point at the top of the range
      load_settings(32'h7FFF_FFFF, 17'h1FFFF, 32'h0001_0000, 40'd0, 17'h1FFFF,
                    48'hFFFF_FFFF_FFFF, 48'h1, 48'h7FFF_FFFF_FFFF);
      send_cell(24'd20, 32'h8000_0000, 31'h7FFF_FFFF, 17'd65536, 31'h7FFF_FFFF);
      send_cell(24'd21, 32'h7FFF_0000, 31'h0100_0000, 17'd30000, 31'h0001_0000);
      send_cell(24'd22, 32'h7FFF_FFFF, 31'h1, 17'd100, 31'h1);
      drain();

      repeat (6) run_random_setting(150);

      $display("checked %0d cells under %0d register settings, including extremes",
               cells_checked, settings_used);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
design/mfds_pkg.sv
design/mfds_front.sv
design/mfds_darcy.sv
design/mfds_div.sv
design/mfds_back.sv
design/melt_fraction_darcy_source.sv
design/mfds_checker.sv
tb/mfds_checker.sv
tb/tb_melt_fraction_darcy_source.sv
